@@ sv/ddtd_pkg.sv @@
// ----------------------------------------------------------------------------
// ddtd_pkg: shared types and constants of the dual decay tone detector
// Fixed field widths, coefficient format, state machine and request types.
// ----------------------------------------------------------------------------
`default_nettype none

package ddtd_pkg;

    // Fixed field widths.
    localparam int CH_BITS       = 3;   // channel number on both streams
    localparam int COEF_BITS     = 18;  // Q1.17 coefficients
    localparam int COEF_FRAC     = 17;
    localparam int MAG_BITS      = 24;  // magnitude result
    localparam int DIFF_BITS     = MAG_BITS + 2;  // clamped difference, +-2^24
    localparam int CFG_ADDR_BITS = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_FAST_RE = 2'd0,
        CFG_FAST_IM = 2'd1,
        CFG_SLOW_RE = 2'd2,
        CFG_SLOW_IM = 2'd3
    } cfg_reg_t;

    // State component being updated; also its slot in the memory word.
    typedef enum logic [1:0] {
        COMP_FAST_RE = 2'd0,
        COMP_FAST_IM = 2'd1,
        COMP_SLOW_RE = 2'd2,
        COMP_SLOW_IM = 2'd3
    } comp_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_CALC,
        CS_WRITE
    } core_state_t;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_SQUARE,
        MS_SUM,
        MS_ROOT,
        MS_DONE
    } mag_state_t;

    // Hand-off from the resonator core to the magnitude unit.
    typedef struct packed {
        logic [CH_BITS-1:0]          channel;
        logic                        zero;     // channel out of range
        logic signed [DIFF_BITS-1:0] diff_re;  // slow minus fast, clamped
        logic signed [DIFF_BITS-1:0] diff_im;
    } mag_req_t;

endpackage

`default_nettype wire

@@ sv/ddtd_state_mem.sv @@
// ----------------------------------------------------------------------------
// ddtd_state_mem: per-channel resonator state memory
// One write port, one registered read port, valid bit per entry so that
// entries not yet written since reset read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ddtd_state_mem #(
    parameter int DEPTH      = 8,
    parameter int ADDR_BITS  = 3,
    parameter int DATA_BITS  = 96
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [DATA_BITS-1:0] rd_data,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    logic [DATA_BITS-1:0] rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

    // The core sequences its accesses so a read never meets a write to the
    // same entry; the read would otherwise see stale data.
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("state memory read and write hit the same entry");

endmodule

`default_nettype wire

@@ sv/ddtd_core.sv @@
// ----------------------------------------------------------------------------
// ddtd_core: resonator read-modify-write core
// Reads a channel's four state components, updates them one per cycle with a
// shared pair of multipliers, writes them back and hands the differences on.
// ----------------------------------------------------------------------------
`default_nettype none

module ddtd_core #(
    parameter int NUM_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 16,
    parameter int STATE_BITS   = 24,
    parameter int ADDR_BITS    = 3
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wen,
    input  wire logic [ddtd_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  wire logic [ddtd_pkg::COEF_BITS-1:0]         cfg_wdata,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [ddtd_pkg::CH_BITS-1:0]           in_channel,
    input  wire logic [SAMPLE_BITS-1:0]                 in_sample,
    output logic                                        mem_rd_en,
    output logic      [ADDR_BITS-1:0]                   mem_rd_addr,
    input  wire logic [4*STATE_BITS-1:0]                mem_rd_data,
    output logic                                        mem_wr_en,
    output logic      [ADDR_BITS-1:0]                   mem_wr_addr,
    output logic      [4*STATE_BITS-1:0]                mem_wr_data,
    output logic                                        req_valid,
    input  wire logic                                   req_ready,
    output ddtd_pkg::mag_req_t                          req
);

    localparam int SB  = STATE_BITS;
    localparam int CB  = ddtd_pkg::COEF_BITS;
    localparam int CF  = ddtd_pkg::COEF_FRAC;
    localparam int PW  = SB + CB;                 // product width
    localparam int RW  = SB + 2;                  // rounded sum width
    localparam int TW  = ((RW > SAMPLE_BITS) ? RW : SAMPLE_BITS) + 1;
    localparam int CHW = ((ADDR_BITS > ddtd_pkg::CH_BITS) ? ADDR_BITS
                                                          : ddtd_pkg::CH_BITS) + 1;
    localparam int XW  = ((SB + 1) > ddtd_pkg::DIFF_BITS) ? (SB + 1) : ddtd_pkg::DIFF_BITS;
    localparam int MB  = ddtd_pkg::MAG_BITS;

    localparam logic signed [PW:0]   RND_HALF = {{(PW + 1 - CF){1'b0}}, 1'b1, {(CF - 1){1'b0}}};
    localparam logic signed [TW-1:0] SMAX     = {{(TW - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
    localparam logic signed [TW-1:0] SMIN     = {{(TW - SB + 1){1'b1}}, {(SB - 1){1'b0}}};
    localparam logic signed [XW-1:0] LIM_P    = {{(XW - MB - 1){1'b0}}, 1'b1, {MB{1'b0}}};
    localparam logic signed [XW-1:0] LIM_N    = {{(XW - MB){1'b1}}, {MB{1'b0}}};
    localparam logic [2:0]           LAST_CNT = 3'd4;

    ddtd_pkg::core_state_t state_reg, state_next;

    logic signed [CB-1:0] fast_re_reg, fast_im_reg, slow_re_reg, slow_im_reg;

    logic [2:0]                        cnt_reg, cnt_next;
    logic signed [SAMPLE_BITS-1:0]     x_reg;
    logic [ddtd_pkg::CH_BITS-1:0]      ch_reg;
    logic [ADDR_BITS-1:0]              addr_reg;
    logic                              in_range_reg;
    logic signed [PW-1:0]              pa_reg, pb_reg;
    logic                              sub_reg, addx_reg;
    ddtd_pkg::comp_t                   kidx_reg;
    logic signed [SB-1:0]              ns_reg [4];

    logic [CHW-1:0]       ch_ext;
    logic                 ch_in_range;
    logic signed [SB-1:0] old_fr, old_fi, old_sr, old_si;
    logic signed [SB-1:0] a_sel, b_sel;
    logic signed [CB-1:0] c_sel, d_sel;
    logic                 sub_sel, addx_sel;
    logic signed [PW-1:0] a_ext, b_ext, c_ext, d_ext, prod_a, prod_b;
    logic signed [PW:0]   sum_full;
    logic signed [RW-1:0] rnd;
    logic signed [TW-1:0] tot;
    logic signed [SB-1:0] sat_val;
    logic signed [XW-1:0] dre_full, dim_full, dre_clamp, dim_clamp;
    logic                 calc_issue, calc_retire;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_re_reg <= '0;
            fast_im_reg <= '0;
            slow_re_reg <= '0;
            slow_im_reg <= '0;
        end else if (cfg_wen) begin
            unique case (ddtd_pkg::cfg_reg_t'(cfg_addr))
                ddtd_pkg::CFG_FAST_RE: fast_re_reg <= cfg_wdata;
                ddtd_pkg::CFG_FAST_IM: fast_im_reg <= cfg_wdata;
                ddtd_pkg::CFG_SLOW_RE: slow_re_reg <= cfg_wdata;
                ddtd_pkg::CFG_SLOW_IM: slow_im_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign ch_ext      = CHW'(in_channel);
    assign ch_in_range = (ch_ext < CHW'(NUM_CHANNELS));

    assign old_fr = mem_rd_data[0*SB +: SB];
    assign old_fi = mem_rd_data[1*SB +: SB];
    assign old_sr = mem_rd_data[2*SB +: SB];
    assign old_si = mem_rd_data[3*SB +: SB];

    // Operand selection: real part is pr*wr - pi*wi (+ sample),
    // imaginary part is pr*wi + pi*wr.
    always_comb begin
        unique case (ddtd_pkg::comp_t'(cnt_reg[1:0]))
            ddtd_pkg::COMP_FAST_RE: begin
                a_sel = old_fr; c_sel = fast_re_reg; b_sel = old_fi; d_sel = fast_im_reg;
                sub_sel = 1'b1; addx_sel = 1'b1;
            end
            ddtd_pkg::COMP_FAST_IM: begin
                a_sel = old_fr; c_sel = fast_im_reg; b_sel = old_fi; d_sel = fast_re_reg;
                sub_sel = 1'b0; addx_sel = 1'b0;
            end
            ddtd_pkg::COMP_SLOW_RE: begin
                a_sel = old_sr; c_sel = slow_re_reg; b_sel = old_si; d_sel = slow_im_reg;
                sub_sel = 1'b1; addx_sel = 1'b1;
            end
            ddtd_pkg::COMP_SLOW_IM: begin
                a_sel = old_sr; c_sel = slow_im_reg; b_sel = old_si; d_sel = slow_re_reg;
                sub_sel = 1'b0; addx_sel = 1'b0;
            end
            default: begin
                a_sel = old_fr; c_sel = fast_re_reg; b_sel = old_fi; d_sel = fast_im_reg;
                sub_sel = 1'b1; addx_sel = 1'b1;
            end
        endcase
    end

    assign a_ext  = {{CB{a_sel[SB-1]}}, a_sel};
    assign b_ext  = {{CB{b_sel[SB-1]}}, b_sel};
    assign c_ext  = {{SB{c_sel[CB-1]}}, c_sel};
    assign d_ext  = {{SB{d_sel[CB-1]}}, d_sel};
    assign prod_a = a_ext * c_ext;
    assign prod_b = b_ext * d_ext;

    // Round to nearest (ties up), add the sample, saturate.
    always_comb begin
        if (sub_reg) begin
            sum_full = {pa_reg[PW-1], pa_reg} - {pb_reg[PW-1], pb_reg} + RND_HALF;
        end else begin
            sum_full = {pa_reg[PW-1], pa_reg} + {pb_reg[PW-1], pb_reg} + RND_HALF;
        end
        rnd = sum_full[PW:CF];
        tot = {{(TW - RW){rnd[RW-1]}}, rnd}
            + (addx_reg ? {{(TW - SAMPLE_BITS){x_reg[SAMPLE_BITS-1]}}, x_reg} : TW'(0));
        if (tot > SMAX) begin
            sat_val = SMAX[SB-1:0];
        end else if (tot < SMIN) begin
            sat_val = SMIN[SB-1:0];
        end else begin
            sat_val = tot[SB-1:0];
        end
    end

    // Slow minus fast, clamped to the magnitude range.
    always_comb begin
        dre_full = {{(XW - SB){ns_reg[ddtd_pkg::COMP_SLOW_RE][SB-1]}},
                    ns_reg[ddtd_pkg::COMP_SLOW_RE]}
                 - {{(XW - SB){ns_reg[ddtd_pkg::COMP_FAST_RE][SB-1]}},
                    ns_reg[ddtd_pkg::COMP_FAST_RE]};
        dim_full = {{(XW - SB){ns_reg[ddtd_pkg::COMP_SLOW_IM][SB-1]}},
                    ns_reg[ddtd_pkg::COMP_SLOW_IM]}
                 - {{(XW - SB){ns_reg[ddtd_pkg::COMP_FAST_IM][SB-1]}},
                    ns_reg[ddtd_pkg::COMP_FAST_IM]};
        dre_clamp = (dre_full > LIM_P) ? LIM_P : ((dre_full < LIM_N) ? LIM_N : dre_full);
        dim_clamp = (dim_full > LIM_P) ? LIM_P : ((dim_full < LIM_N) ? LIM_N : dim_full);
    end

    assign req.channel = ch_reg;
    assign req.zero    = !in_range_reg;
    assign req.diff_re = dre_clamp[ddtd_pkg::DIFF_BITS-1:0];
    assign req.diff_im = dim_clamp[ddtd_pkg::DIFF_BITS-1:0];

    assign mem_wr_addr = addr_reg;
    assign mem_wr_data = {ns_reg[ddtd_pkg::COMP_SLOW_IM], ns_reg[ddtd_pkg::COMP_SLOW_RE],
                          ns_reg[ddtd_pkg::COMP_FAST_IM], ns_reg[ddtd_pkg::COMP_FAST_RE]};
    assign mem_rd_addr = ch_ext[ADDR_BITS-1:0];

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        in_ready    = 1'b0;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        req_valid   = 1'b0;
        calc_issue  = 1'b0;
        calc_retire = 1'b0;
        unique case (state_reg)
            ddtd_pkg::CS_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    mem_rd_en  = 1'b1;
                    cnt_next   = '0;
                    state_next = ddtd_pkg::CS_CALC;
                end
            end
            ddtd_pkg::CS_CALC: begin
                // Products of component cnt are issued while cnt-1 is finished.
                calc_issue  = (cnt_reg != LAST_CNT);
                calc_retire = (cnt_reg != 3'd0);
                cnt_next    = cnt_reg + 3'd1;
                if (cnt_reg == LAST_CNT) begin
                    state_next = ddtd_pkg::CS_WRITE;
                end
            end
            ddtd_pkg::CS_WRITE: begin
                req_valid = 1'b1;
                if (req_ready) begin
                    mem_wr_en  = in_range_reg;
                    state_next = ddtd_pkg::CS_IDLE;
                end
            end
            default: state_next = ddtd_pkg::CS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ddtd_pkg::CS_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            x_reg        <= in_sample;
            ch_reg       <= in_channel;
            addr_reg     <= ch_ext[ADDR_BITS-1:0];
            in_range_reg <= ch_in_range;
        end
        if (calc_issue) begin
            pa_reg   <= prod_a;
            pb_reg   <= prod_b;
            sub_reg  <= sub_sel;
            addx_reg <= addx_sel;
            kidx_reg <= ddtd_pkg::comp_t'(cnt_reg[1:0]);
        end
        if (calc_retire) begin
            ns_reg[kidx_reg] <= sat_val;
        end
    end

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (in_range_reg && state_reg == ddtd_pkg::CS_WRITE))
        else $error("state written back for an out-of-range channel");

    a_calc_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ddtd_pkg::CS_CALC && cnt_reg == LAST_CNT)
            |=> (state_reg == ddtd_pkg::CS_WRITE))
        else $error("resonator update did not finish after four components");

endmodule

`default_nettype wire

@@ sv/ddtd_mag_unit.sv @@
// ----------------------------------------------------------------------------
// ddtd_mag_unit: magnitude of the resonator difference
// Squares both components, sums them and takes a saturating integer square
// root two result bits per cycle; result held in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ddtd_mag_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               req_valid,
    output logic                                    req_ready,
    input  wire ddtd_pkg::mag_req_t                 req,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [ddtd_pkg::MAG_BITS-1:0]           m_tdata,
    output logic [ddtd_pkg::CH_BITS-1:0]            m_tuser
);

    localparam int MB    = ddtd_pkg::MAG_BITS;
    localparam int DB    = ddtd_pkg::DIFF_BITS;
    localparam int ABSW  = MB + 1;          // |diff| <= 2^24
    localparam int SQW   = 2 * MB + 1;      // square <= 2^48
    localparam int RADW  = 2 * MB;          // radicand below saturation
    localparam int REMW  = MB + 2;
    localparam int STEPS = MB / 2;          // two root bits per cycle
    localparam int ITW   = $clog2(STEPS);
    localparam logic [ITW-1:0] LAST_STEP = ITW'(STEPS - 1);

    ddtd_pkg::mag_state_t state_reg, state_next;

    logic [ddtd_pkg::CH_BITS-1:0] ch_reg;
    logic                         zero_reg;
    logic signed [DB-1:0]         dre_reg, dim_reg;
    logic [SQW-1:0]               sqr_reg, sqi_reg;
    logic                         sat_reg;
    logic [RADW-1:0]              rad_reg, rad_step;
    logic [REMW-1:0]              rem_reg, rem_step;
    logic [MB-1:0]                root_reg, root_step;
    logic [ITW-1:0]               iter_reg;
    logic                         out_valid_reg;
    logic [MB-1:0]                out_mag_reg;
    logic [ddtd_pkg::CH_BITS-1:0] out_ch_reg;

    logic [DB-1:0]     neg_re, neg_im;
    logic [ABSW-1:0]   abs_re, abs_im;
    logic [2*ABSW-1:0] sq_re_full, sq_im_full;
    logic [SQW:0]      sq_sum;
    logic              out_load;
    logic              take_req;

    assign neg_re     = DB'(0) - dre_reg;
    assign neg_im     = DB'(0) - dim_reg;
    assign abs_re     = dre_reg[DB-1] ? neg_re[ABSW-1:0] : dre_reg[ABSW-1:0];
    assign abs_im     = dim_reg[DB-1] ? neg_im[ABSW-1:0] : dim_reg[ABSW-1:0];
    assign sq_re_full = abs_re * abs_re;
    assign sq_im_full = abs_im * abs_im;
    assign sq_sum     = {1'b0, sqr_reg} + {1'b0, sqi_reg};

    // Two steps of the digit-by-digit square root.
    always_comb begin
        logic [REMW+1:0] trial;
        logic [REMW+1:0] test;
        rem_step  = rem_reg;
        root_step = root_reg;
        rad_step  = rad_reg;
        for (int i = 0; i < 2; i++) begin
            trial = {rem_step, rad_step[RADW-1 -: 2]};
            test  = {2'b00, root_step, 2'b01};
            if (trial >= test) begin
                rem_step  = REMW'(trial - test);
                root_step = {root_step[MB-2:0], 1'b1};
            end else begin
                rem_step  = trial[REMW-1:0];
                root_step = {root_step[MB-2:0], 1'b0};
            end
            rad_step = {rad_step[RADW-3:0], 2'b00};
        end
    end

    // The output register frees as soon as its transfer completes.
    assign out_load = (state_reg == ddtd_pkg::MS_DONE) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        req_ready  = 1'b0;
        take_req   = 1'b0;
        unique case (state_reg)
            ddtd_pkg::MS_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    take_req   = 1'b1;
                    state_next = ddtd_pkg::MS_SQUARE;
                end
            end
            ddtd_pkg::MS_SQUARE: state_next = ddtd_pkg::MS_SUM;
            ddtd_pkg::MS_SUM:    state_next = ddtd_pkg::MS_ROOT;
            ddtd_pkg::MS_ROOT: begin
                if (iter_reg == LAST_STEP) begin
                    state_next = ddtd_pkg::MS_DONE;
                end
            end
            ddtd_pkg::MS_DONE: begin
                if (out_load) begin
                    state_next = ddtd_pkg::MS_IDLE;
                end
            end
            default: state_next = ddtd_pkg::MS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ddtd_pkg::MS_IDLE;
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ddtd_pkg::MS_SUM) begin
                iter_reg <= '0;
            end else if (state_reg == ddtd_pkg::MS_ROOT) begin
                iter_reg <= iter_reg + ITW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_req) begin
            ch_reg   <= req.channel;
            zero_reg <= req.zero;
            dre_reg  <= req.diff_re;
            dim_reg  <= req.diff_im;
        end
        if (state_reg == ddtd_pkg::MS_SQUARE) begin
            sqr_reg <= sq_re_full[SQW-1:0];
            sqi_reg <= sq_im_full[SQW-1:0];
        end
        if (state_reg == ddtd_pkg::MS_SUM) begin
            // A sum of 2^48 or more has a root beyond the result range.
            sat_reg  <= |sq_sum[SQW:RADW];
            rad_reg  <= sq_sum[RADW-1:0];
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (state_reg == ddtd_pkg::MS_ROOT) begin
            rad_reg  <= rad_step;
            rem_reg  <= rem_step;
            root_reg <= root_step;
        end
        if (out_load) begin
            out_ch_reg <= ch_reg;
            if (zero_reg) begin
                out_mag_reg <= '0;
            end else if (sat_reg) begin
                out_mag_reg <= '1;
            end else begin
                out_mag_reg <= root_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_mag_reg;
    assign m_tuser  = out_ch_reg;

    a_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && zero_reg) |=> (m_tvalid && m_tdata == '0))
        else $error("out-of-range channel gave a nonzero magnitude");

    a_root_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ddtd_pkg::MS_ROOT && iter_reg == LAST_STEP)
            |=> (state_reg == ddtd_pkg::MS_DONE))
        else $error("square root did not end after its last step");

endmodule

`default_nettype wire

@@ sv/dual_decay_tone_detector_unit.sv @@
// ----------------------------------------------------------------------------
// dual_decay_tone_detector_unit: per-channel dual resonator tone detector
// Each sample updates a fast and a slow complex one-pole resonator of its
// channel and yields the magnitude of slow minus fast.
//
//  Group      Dir  Signals                         Contents
//  s_         in   s_tvalid s_tready s_tdata       audio_sample
//                  s_tuser                         channel_index
//  m_         out  m_tvalid m_tready m_tdata       tone_magnitude
//                  m_tuser                         result_channel
//  cfg_       in   cfg_wen cfg_addr cfg_wdata      coefficient writes
//
// A sample passes through the resonator core (memory read, four component
// updates through one shared multiplier pair, write-back) and then the
// square-root unit, which produces two result bits per cycle; the root
// unit sets the sustained sample rate.
// The state memory reads as zero after reset; no clearing pass is needed.
// A stalled output holds its result while the next sample is processed.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_decay_tone_detector_unit #(
    parameter int NUM_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 16,
    parameter int STATE_BITS   = 24
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // configuration
    input  wire logic                                   cfg_wen,
    input  wire logic [ddtd_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  wire logic [ddtd_pkg::COEF_BITS-1:0]         cfg_wdata,
    // samples
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // s_tdata: audio_sample, zero-padded to whole bytes
    input  wire logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,
    // s_tuser: channel_index
    input  wire logic [ddtd_pkg::CH_BITS-1:0]           s_tuser,
    // results
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // m_tdata: tone_magnitude
    output logic [ddtd_pkg::MAG_BITS-1:0]               m_tdata,
    // m_tuser: result_channel
    output logic [ddtd_pkg::CH_BITS-1:0]                m_tuser
);

    localparam int ADDR_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int WORD_BITS = 4 * STATE_BITS;

    logic                 mem_rd_en, mem_wr_en;
    logic [ADDR_BITS-1:0] mem_rd_addr, mem_wr_addr;
    logic [WORD_BITS-1:0] mem_rd_data, mem_wr_data;
    logic                 req_valid, req_ready;
    ddtd_pkg::mag_req_t   req;

    ddtd_core #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .STATE_BITS   (STATE_BITS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_channel  (s_tuser),
        .in_sample   (s_tdata[SAMPLE_BITS-1:0]),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req)
    );

    ddtd_state_mem #(
        .DEPTH     (NUM_CHANNELS),
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (WORD_BITS)
    ) u_state_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    ddtd_mag_unit u_mag (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

@@ tb/tb_dual_decay_tone_detector_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_decay_tone_detector_unit: self-checking bench of the tone detector
// Drives audio samples on random channels through the sample stream. It keeps
// its own per-channel fast and slow resonator state and checks every returned
// magnitude and channel in order. The bench steps through several coefficient
// settings, the extremes among them. Both stream sides idle at random.
// ----------------------------------------------------------------------------

module tb_dual_decay_tone_detector_unit;

    localparam int NUM_CH      = 8;
    localparam int SAMPLE_W    = 16;
    localparam int STATE_W     = 24;
    localparam int DATA_W      = ((SAMPLE_W + 7) / 8) * 8;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 203;
    localparam int STEADY_PH   = 3;
    localparam int TAIL_CYCLES = 60;
    localparam int REPORT_MAX  = 10;
    localparam longint unsigned MAG_MAX = (64'd1 << ddtd_pkg::MAG_BITS) - 1;

    typedef struct packed {
        logic [ddtd_pkg::CH_BITS-1:0]  ch;
        logic [ddtd_pkg::MAG_BITS-1:0] mag;
    } tone_result_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_SAMPLE
    } row_kind_t;

    typedef struct {
        row_kind_t                      kind;
        ddtd_pkg::cfg_reg_t             reg_sel;
        logic [ddtd_pkg::COEF_BITS-1:0] value;
        logic [ddtd_pkg::CH_BITS-1:0]   ch;
        logic [SAMPLE_W-1:0]            sample;
        bit                             has_value;
        logic [ddtd_pkg::MAG_BITS-1:0]  mag;
    } stim_row_t;

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 cfg_wen;
    logic [ddtd_pkg::CFG_ADDR_BITS-1:0]   cfg_addr;
    logic [ddtd_pkg::COEF_BITS-1:0]       cfg_wdata;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [DATA_W-1:0]                    s_tdata;
    logic [ddtd_pkg::CH_BITS-1:0]         s_tuser;
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic [ddtd_pkg::MAG_BITS-1:0]        m_tdata;
    logic [ddtd_pkg::CH_BITS-1:0]         m_tuser;

    // Fixed expectation travelling with the sample, used by directed rows.
    bit                                   row_has_value;
    logic [ddtd_pkg::MAG_BITS-1:0]        row_magnitude;

    bit                                   gaps_on;
    int                                   fail_count;
    tone_result_t                         pending_tones[$];
    stim_row_t                            directed_rows[$];

    logic signed [STATE_W-1:0]             res_state [NUM_CH][4];
    logic signed [ddtd_pkg::COEF_BITS-1:0] coef_model [4];

    dual_decay_tone_detector_unit #(
        .NUM_CHANNELS (NUM_CH),
        .SAMPLE_BITS  (SAMPLE_W),
        .STATE_BITS   (STATE_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Complex product term scaled by 2^-17, rounded with ties toward +infinity.
    function automatic longint scaled_product(input longint a, input longint c,
                                              input longint b, input longint d);
        return (a * c - b * d + (64'sd1 <<< (ddtd_pkg::COEF_FRAC - 1)))
               >>> ddtd_pkg::COEF_FRAC;
    endfunction

    function automatic longint clip_state(input longint v);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (STATE_W - 1)) - 1;
        lo = -(64'sd1 <<< (STATE_W - 1));
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Advances both resonators of the channel and returns |slow - fast|.
    function automatic logic [ddtd_pkg::MAG_BITS-1:0] predict_tone_magnitude(
            input logic [ddtd_pkg::CH_BITS-1:0] ch,
            input logic signed [SAMPLE_W-1:0] sample);
        longint xs, fcr, fci, scr, sci;
        longint fr, fi, sr, si, dr, di;
        longint unsigned root;
        xs  = sample;
        fcr = coef_model[ddtd_pkg::CFG_FAST_RE];
        fci = coef_model[ddtd_pkg::CFG_FAST_IM];
        scr = coef_model[ddtd_pkg::CFG_SLOW_RE];
        sci = coef_model[ddtd_pkg::CFG_SLOW_IM];
        fr = clip_state(scaled_product(res_state[ch][ddtd_pkg::COMP_FAST_RE], fcr,
                                       res_state[ch][ddtd_pkg::COMP_FAST_IM], fci) + xs);
        fi = clip_state(scaled_product(res_state[ch][ddtd_pkg::COMP_FAST_RE], fci,
                                       res_state[ch][ddtd_pkg::COMP_FAST_IM], -fcr));
        sr = clip_state(scaled_product(res_state[ch][ddtd_pkg::COMP_SLOW_RE], scr,
                                       res_state[ch][ddtd_pkg::COMP_SLOW_IM], sci) + xs);
        si = clip_state(scaled_product(res_state[ch][ddtd_pkg::COMP_SLOW_RE], sci,
                                       res_state[ch][ddtd_pkg::COMP_SLOW_IM], -scr));
        res_state[ch][ddtd_pkg::COMP_FAST_RE] = fr[STATE_W-1:0];
        res_state[ch][ddtd_pkg::COMP_FAST_IM] = fi[STATE_W-1:0];
        res_state[ch][ddtd_pkg::COMP_SLOW_RE] = sr[STATE_W-1:0];
        res_state[ch][ddtd_pkg::COMP_SLOW_IM] = si[STATE_W-1:0];
        // Differences of two saturated states never exceed 2^24 in size, so no
        // clamp is needed before squaring.
        dr = sr - fr;
        di = si - fi;
        root = floor_sqrt(longint'(dr * dr + di * di));
        if (root > MAG_MAX)
            root = MAG_MAX;
        return root[ddtd_pkg::MAG_BITS-1:0];
    endfunction

    function automatic logic [ddtd_pkg::COEF_BITS-1:0] pick_coef();
        int v;
        case ($urandom_range(0, 7))
            0: v = 131071;
            1: v = -131072;
            2: v = 0;
            3: v = int'($urandom_range(0, 262143)) - 131072;
            default: v = int'($urandom_range(0, 184000)) - 92000;
        endcase
        return v[ddtd_pkg::COEF_BITS-1:0];
    endfunction

    function automatic void add_write(input ddtd_pkg::cfg_reg_t sel, input int value);
        stim_row_t row;
        row = '{kind: ROW_WRITE, reg_sel: sel, value: value[ddtd_pkg::COEF_BITS-1:0],
                ch: '0, sample: '0, has_value: 1'b0, mag: '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_sample(input int ch, input int sample,
                                       input bit has_value, input int mag);
        stim_row_t row;
        row = '{kind: ROW_SAMPLE, reg_sel: ddtd_pkg::CFG_FAST_RE, value: '0,
                ch: ch[ddtd_pkg::CH_BITS-1:0], sample: sample[SAMPLE_W-1:0],
                has_value: has_value, mag: mag[ddtd_pkg::MAG_BITS-1:0]};
        directed_rows.push_back(row);
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: %s", $realtime, msg);
    endfunction

    task automatic send_sample(input logic [ddtd_pkg::CH_BITS-1:0] ch,
                               input logic [SAMPLE_W-1:0] sample,
                               input bit has_value,
                               input logic [ddtd_pkg::MAG_BITS-1:0] mag);
        cfg_wen <= 1'b0;
        while (gaps_on && $urandom_range(0, 99) < 27) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid      <= 1'b1;
        s_tdata       <= DATA_W'(sample);
        s_tuser       <= ch;
        row_has_value <= has_value;
        row_magnitude <= mag;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_tones.size() != 0)
            @(negedge aclk);
    endtask

    // Only called while nothing is in flight, so the model may change at once.
    task automatic write_coef(input ddtd_pkg::cfg_reg_t sel,
                              input logic [ddtd_pkg::COEF_BITS-1:0] value);
        cfg_wen         <= 1'b1;
        cfg_addr        <= sel;
        cfg_wdata       <= value;
        coef_model[sel] = value;
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_tready <= !gaps_on || ($urandom_range(0, 99) >= 27);
    end

    // Results are checked before the accepted sample is predicted; a result
    // never leaves in the cycle its sample enters.
    always @(posedge aclk) begin : tone_check
        tone_result_t want;
        tone_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{ch: m_tuser, mag: m_tdata};
            if (pending_tones.size() == 0) begin
                note_failure($sformatf("unexpected result: channel %0d magnitude %0d",
                                       got.ch, got.mag));
            end else begin
                want = pending_tones.pop_front();
                if (got.ch !== want.ch)
                    note_failure($sformatf("channel: expected %0d, got %0d",
                                           want.ch, got.ch));
                if (got.mag !== want.mag)
                    note_failure($sformatf("magnitude on channel %0d: expected %0d, got %0d",
                                           want.ch, want.mag, got.mag));
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            want.ch  = s_tuser;
            want.mag = predict_tone_magnitude(s_tuser, $signed(s_tdata[SAMPLE_W-1:0]));
            if (row_has_value)
                want.mag = row_magnitude;
            pending_tones.push_back(want);
        end
    end

    initial begin : stimulus
        logic [ddtd_pkg::COEF_BITS-1:0] c_fr, c_fi, c_sr, c_si;
        logic [ddtd_pkg::CH_BITS-1:0]   burst_ch;
        logic [SAMPLE_W-1:0]            x;
        int                             tone_amp;
        int                             tone_half;
        int                             small_val;
        int                             ch_pick;

        aclk          = 1'b0;
        aresetn       = 1'b0;
        cfg_wen       = 1'b0;
        cfg_addr      = ddtd_pkg::CFG_FAST_RE;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        row_has_value = 1'b0;
        row_magnitude = '0;
        gaps_on       = 1'b1;
        fail_count    = 0;
        foreach (res_state[i, j])
            res_state[i][j] = '0;
        foreach (coef_model[i])
            coef_model[i] = '0;

        // With all coefficients at zero both resonators equal the sample, so
        // the magnitude is zero on every channel.
        add_sample(0, 32767, 1, 0);
        add_sample(1, -32768, 1, 0);
        add_sample(2, 0, 1, 0);
        add_sample(3, -1, 1, 0);
        add_sample(4, 1, 1, 0);
        add_sample(5, 21845, 1, 0);
        add_sample(6, -21846, 1, 0);
        add_sample(7, 12345, 1, 0);
        // Slow resonator as an integrator, fast one passes the sample.
        add_write(ddtd_pkg::CFG_SLOW_RE, 131071);
        add_sample(0, 32767, 0, 0);
        add_sample(0, 32767, 0, 0);
        add_sample(0, 32767, 0, 0);
        add_sample(1, -32768, 0, 0);
        // Coefficients at the negative and positive extremes.
        add_write(ddtd_pkg::CFG_FAST_RE, -131072);
        add_write(ddtd_pkg::CFG_FAST_IM, -131072);
        add_write(ddtd_pkg::CFG_SLOW_IM, 131071);
        add_sample(0, 32767, 0, 0);
        add_sample(0, 32767, 0, 0);
        add_sample(0, 32767, 0, 0);
        add_sample(2, -32768, 0, 0);
        add_sample(2, -32768, 0, 0);
        add_sample(2, -32768, 0, 0);
        // Zero coefficients wipe the history again.
        add_write(ddtd_pkg::CFG_FAST_RE, 0);
        add_write(ddtd_pkg::CFG_FAST_IM, 0);
        add_write(ddtd_pkg::CFG_SLOW_RE, 0);
        add_write(ddtd_pkg::CFG_SLOW_IM, 0);
        add_sample(0, 32767, 1, 0);
        add_sample(5, -32768, 1, 0);
        add_write(ddtd_pkg::CFG_FAST_RE, 131071);
        add_write(ddtd_pkg::CFG_SLOW_RE, -131072);
        add_write(ddtd_pkg::CFG_SLOW_IM, -131072);
        repeat (5)
            add_sample(3, 32767, 0, 0);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                wait_idle();
                write_coef(directed_rows[i].reg_sel, directed_rows[i].value);
            end else begin
                send_sample(directed_rows[i].ch, directed_rows[i].sample,
                            directed_rows[i].has_value, directed_rows[i].mag);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0) begin
                // Opposite extreme rotations drive the difference into saturation.
                c_fr = 18'sd131071;
                c_fi = 18'sd131071;
                c_sr = -18'sd131072;
                c_si = -18'sd131072;
            end else if (ph == 1) begin
                c_fr = '0;
                c_fi = '0;
                c_sr = 18'sd131071;
                c_si = '0;
            end else begin
                c_fr = pick_coef();
                c_fi = pick_coef();
                c_sr = pick_coef();
                c_si = pick_coef();
            end
            wait_idle();
            write_coef(ddtd_pkg::CFG_FAST_RE, c_fr);
            write_coef(ddtd_pkg::CFG_FAST_IM, c_fi);
            write_coef(ddtd_pkg::CFG_SLOW_RE, c_sr);
            write_coef(ddtd_pkg::CFG_SLOW_IM, c_si);
            gaps_on   = (ph != STEADY_PH);
            tone_amp  = $urandom_range(1, 32767);
            tone_half = $urandom_range(1, 12);
            ch_pick   = $urandom_range(0, NUM_CH - 1);
            burst_ch  = ch_pick[ddtd_pkg::CH_BITS-1:0];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Mostly bursts on one channel, so a resonator sees a real tone.
                if ($urandom_range(0, 99) >= 60) begin
                    ch_pick  = $urandom_range(0, NUM_CH - 1);
                    burst_ch = ch_pick[ddtd_pkg::CH_BITS-1:0];
                end
                case ($urandom_range(0, 9))
                    0: x = 16'h7fff;
                    1: x = 16'h8000;
                    2: begin
                        small_val = int'($urandom_range(0, 6)) - 3;
                        x = small_val[SAMPLE_W-1:0];
                    end
                    3, 4, 5: begin
                        small_val = ((n / tone_half) % 2 != 0) ? -tone_amp : tone_amp;
                        x = small_val[SAMPLE_W-1:0];
                    end
                    default: x = SAMPLE_W'($urandom());
                endcase
                send_sample(burst_ch, x, 1'b0, '0);
            end
        end

        gaps_on = 1'b1;
        wait_idle();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending_tones.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
